// ----- rtl/phe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_pkg: shared types and constants of the polynomial evaluator
// Formats, register indexes and the data word handed from cell to cell.
// ----------------------------------------------------------------------------
package phe_pkg;

  localparam int MAX_DEGREE = 6;
  localparam int NUM_COEFS  = MAX_DEGREE + 1;
  localparam int NUM_CELLS  = MAX_DEGREE;

  localparam int DEG_W      = 3;
  localparam int COEF_W     = 32;
  localparam int X_W        = 18;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COEF_W + X_W;
  localparam int RND_W      = PROD_W + 1;
  localparam int SHIFT_W    = RND_W - FRAC_W;
  localparam int SUM_W      = SHIFT_W + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam int IN_DATA_W  = ((X_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COEF_W + 1 + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEGREE = 3'd0,
    REG_COEF_0 = 3'd1,
    REG_COEF_1 = 3'd2,
    REG_COEF_2 = 3'd3,
    REG_COEF_3 = 3'd4,
    REG_COEF_4 = 3'd5,
    REG_COEF_5 = 3'd6,
    REG_COEF_6 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [X_W-1:0]    x;
    logic signed [COEF_W-1:0] acc;
    logic                     ovf;
  } cell_data_t;

endpackage

// ----- rtl/polynomial_horner_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_horner_evaluator: fixed-point polynomial evaluation
// Horner's rule over a row of multiply-round-add cells, one cell per step.
//
//   channel  ports        payload (low bit up)
//   input    in_t*        x_value[17:0]
//   output   out_t*       y_value[31:0], overflow[32]
//   config   cfg_*        index 0 degree, 1..7 coef_0..coef_6
//
// One item enters per cycle while the output is not stalled; the path runs
// through the input register, then a multiply stage and a round/add stage in each cell.
// Reset clears degree, coefficients and all valid bits.
// A stalled output freezes the whole row; in_tready falls with it.
// ----------------------------------------------------------------------------
module polynomial_horner_evaluator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [phe_pkg::IN_DATA_W-1:0]       in_tdata,   // x_value[17:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [phe_pkg::OUT_DATA_W-1:0]      out_tdata,  // y_value[31:0], overflow[32]
  input  logic                                cfg_wr_en,
  input  logic [phe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [phe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [phe_pkg::DEG_W-1:0]          degree_r;
  logic signed [phe_pkg::COEF_W-1:0]  coef_r [phe_pkg::NUM_COEFS];
  logic [phe_pkg::DEG_W-1:0]          deg_eff;
  logic [phe_pkg::NUM_CELLS-1:0]      active;
  logic                               en;
  phe_pkg::cell_data_t                head_r;
  phe_pkg::cell_data_t                head_nxt;
  phe_pkg::cell_data_t                link [phe_pkg::NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      for (int i = 0; i < phe_pkg::NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (phe_pkg::cfg_reg_t'(cfg_addr))
        phe_pkg::REG_DEGREE: degree_r  <= cfg_wdata[phe_pkg::DEG_W-1:0];
        phe_pkg::REG_COEF_0: coef_r[0] <= cfg_wdata;
        phe_pkg::REG_COEF_1: coef_r[1] <= cfg_wdata;
        phe_pkg::REG_COEF_2: coef_r[2] <= cfg_wdata;
        phe_pkg::REG_COEF_3: coef_r[3] <= cfg_wdata;
        phe_pkg::REG_COEF_4: coef_r[4] <= cfg_wdata;
        phe_pkg::REG_COEF_5: coef_r[5] <= cfg_wdata;
        phe_pkg::REG_COEF_6: coef_r[6] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (degree_r > phe_pkg::DEG_W'(phe_pkg::MAX_DEGREE)) begin
      deg_eff = phe_pkg::DEG_W'(phe_pkg::MAX_DEGREE);
    end else begin
      deg_eff = degree_r;
    end
    for (int k = 0; k < phe_pkg::NUM_CELLS; k++) begin
      active[k] = (phe_pkg::DEG_W'(phe_pkg::NUM_CELLS - 1 - k) < deg_eff);
    end
  end

  assign en        = !link[phe_pkg::NUM_CELLS].valid || out_tready;
  assign in_tready = en;

  always_comb begin
    head_nxt.valid = in_tvalid;
    head_nxt.x     = in_tdata[phe_pkg::X_W-1:0];
    head_nxt.acc   = coef_r[deg_eff];
    head_nxt.ovf   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (en) begin
      head_r.valid <= head_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r.x   <= head_nxt.x;
      head_r.acc <= head_nxt.acc;
      head_r.ovf <= head_nxt.ovf;
    end
  end

  assign link[0] = head_r;

  for (genvar k = 0; k < phe_pkg::NUM_CELLS; k++) begin : g_cell
    phe_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .active (active[k]),
      .coef   (coef_r[phe_pkg::NUM_CELLS - 1 - k]),
      .d_in   (link[k]),
      .d_out  (link[k+1])
    );
  end

  assign out_tvalid = link[phe_pkg::NUM_CELLS].valid;
  assign out_tdata  = phe_pkg::OUT_DATA_W'({link[phe_pkg::NUM_CELLS].ovf,
                                            link[phe_pkg::NUM_CELLS].acc});

endmodule

// ----- rtl/phe_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_cell: one Horner step
// Stage one multiplies the accumulator by x; stage two rounds, adds the
// coefficient and saturates. An inactive cell passes the accumulator on.
// ----------------------------------------------------------------------------
module phe_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             active,
  input  logic signed [phe_pkg::COEF_W-1:0] coef,
  input  phe_pkg::cell_data_t              d_in,
  output phe_pkg::cell_data_t              d_out
);

  logic                                     a_valid_r;
  logic                                     a_active_r;
  logic signed [phe_pkg::X_W-1:0]           a_x_r;
  logic signed [phe_pkg::COEF_W-1:0]        a_acc_r;
  logic                                     a_ovf_r;
  logic signed [phe_pkg::PROD_W-1:0]        a_prod_r;
  logic signed [phe_pkg::PROD_W-1:0]        prod_nxt;

  logic signed [phe_pkg::RND_W-1:0]         rnd;
  logic signed [phe_pkg::SHIFT_W-1:0]       rnd_sh;
  logic signed [phe_pkg::SUM_W-1:0]         sum;
  logic                                     clip;
  logic signed [phe_pkg::COEF_W-1:0]        sat_val;
  phe_pkg::cell_data_t                      b_nxt;
  phe_pkg::cell_data_t                      b_r;

  assign prod_nxt = d_in.acc * d_in.x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_active_r <= active;
      a_x_r      <= d_in.x;
      a_acc_r    <= d_in.acc;
      a_ovf_r    <= d_in.ovf;
      a_prod_r   <= prod_nxt;
    end
  end

  always_comb begin
    rnd    = phe_pkg::RND_W'(a_prod_r) + phe_pkg::RND_W'(signed'(1 << (phe_pkg::FRAC_W - 1)));
    rnd_sh = rnd[phe_pkg::RND_W-1:phe_pkg::FRAC_W];
    sum    = phe_pkg::SUM_W'(rnd_sh) + phe_pkg::SUM_W'(coef);
    clip   = (sum[phe_pkg::SUM_W-1:phe_pkg::COEF_W-1] != '0) &&
             (sum[phe_pkg::SUM_W-1:phe_pkg::COEF_W-1] != '1);
    if (!clip) begin
      sat_val = sum[phe_pkg::COEF_W-1:0];
    end else if (sum[phe_pkg::SUM_W-1]) begin
      sat_val = {1'b1, {(phe_pkg::COEF_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(phe_pkg::COEF_W-1){1'b1}}};
    end
    b_nxt.valid = a_valid_r;
    b_nxt.x     = a_x_r;
    b_nxt.acc   = a_active_r ? sat_val : a_acc_r;
    b_nxt.ovf   = a_ovf_r | (a_active_r & clip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (en) begin
      b_r.valid <= b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r.x   <= b_nxt.x;
      b_r.acc <= b_nxt.acc;
      b_r.ovf <= b_nxt.ovf;
    end
  end

  assign d_out = b_r;

endmodule

// ----- rtl/phe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_checker: port-level checks of the polynomial evaluator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module phe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [phe_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transfer dropped or changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held off with empty output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[phe_pkg::OUT_DATA_W-1:phe_pkg::COEF_W+1] == '0)
    else $error("output padding bits not zero");

endmodule

bind polynomial_horner_evaluator phe_checker u_phe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/tb_polynomial_horner_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_horner_evaluator: self-checking bench for the Horner evaluator
// Drives x samples over the input stream under a series of coefficient sets.
// A scoreboard class recomputes every value in fixed point and checks each
// result transfer in order. Directed corners come first: saturation at both
// rails, degree clamping, ignored upper coefficients and rounding ties.
// Random sets and samples follow, with bursty input, a stalling output, one
// long output hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_polynomial_horner_evaluator;
  import phe_pkg::*;

  localparam int PIPE_LATENCY   = 1 + 2 * MAX_DEGREE;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 120;

  localparam logic signed [X_W-1:0]    X_MAX     = 18'sh1FFFF;
  localparam logic signed [X_W-1:0]    X_MIN     = 18'sh20000;
  localparam logic signed [X_W-1:0]    X_ONE     = 18'sh10000;
  localparam logic signed [X_W-1:0]    X_HALF    = 18'sh08000;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh80000000;
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sh00010000;
  localparam logic signed [RND_W-1:0]  HALF_LSB  = 1 <<< (FRAC_W - 1);

  typedef struct packed {
    logic signed [COEF_W-1:0] y;
    logic                     ovf;
  } poly_value_t;

  class horner_scoreboard;
    logic [DEG_W-1:0]         degree_q;
    logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
    poly_value_t              pending_q [$];
    int unsigned              n_items;
    int unsigned              n_checked;
    int unsigned              n_ovf;
    int unsigned              n_errors;

    function new();
      degree_q = '0;
      foreach (coef_q[i]) coef_q[i] = '0;
      n_items = 0;
      n_checked = 0;
      n_ovf = 0;
      n_errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_DEGREE)
        degree_q = value[DEG_W-1:0];
      else
        coef_q[int'(idx) - int'(REG_COEF_0)] = value;
    endfunction

    function void note_input(logic signed [X_W-1:0] x);
      logic signed [COEF_W-1:0] accum;
      logic signed [PROD_W-1:0] prod;
      logic signed [RND_W-1:0]  biased;
      logic signed [SUM_W-1:0]  total;
      logic                     clipped;
      int                       top;
      poly_value_t              res;
      top = (degree_q > MAX_DEGREE) ? MAX_DEGREE : int'(degree_q);
      accum = coef_q[top];
      clipped = 1'b0;
      for (int i = top - 1; i >= 0; i--) begin
        prod   = accum * x;
        biased = prod + HALF_LSB;
        total  = (biased >>> FRAC_W) + coef_q[i];
        if (total[SUM_W-1:COEF_W-1] != {(SUM_W-COEF_W+1){total[SUM_W-1]}}) begin
          clipped = 1'b1;
          accum = total[SUM_W-1] ? COEF_MIN : COEF_MAX;
        end else begin
          accum = total[COEF_W-1:0];
        end
      end
      res.y = accum;
      res.ovf = clipped;
      pending_q.push_back(res);
      n_items++;
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= 50)
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(logic signed [COEF_W-1:0] y, logic ovf);
      poly_value_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=%0d ovf=%0b", y, ovf));
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (want.ovf)
        n_ovf++;
      if (y !== want.y)
        report_mismatch($sformatf("result %0d: y=%0d, want %0d", n_checked, y, want.y));
      if (ovf !== want.ovf)
        report_mismatch($sformatf("result %0d: overflow=%0b, want %0b",
                                  n_checked, ovf, want.ovf));
    endtask
  endclass

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_DATA_W-1:0]      in_tdata   = '0;   // x_value[17:0]
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]     out_tdata;         // y_value[31:0], overflow[32]
  logic                      cfg_wr_en  = 1'b0;
  cfg_reg_t                  cfg_addr   = REG_DEGREE;
  logic [CFG_DATA_W-1:0]     cfg_wdata  = '0;

  horner_scoreboard          sb = new();
  bit                        hold_request = 1'b0;
  bit                        gaps_on = 1'b0;
  int                        burst_left = 0;
  int unsigned               stall_cycles = 0;
  int unsigned               n_sets = 0;
  logic [DEG_W-1:0]          next_degree;
  logic [COEF_W-1:0]         next_coef [NUM_COEFS];

  polynomial_horner_evaluator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tdata[X_W-1:0]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[COEF_W-1:0], out_tdata[COEF_W]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, stall_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // output side: stall pattern picked at random, with a long hold-off on request
  initial begin : rx_pattern
    int mode_sel;
    int span_left;
    int hold_left;
    int rx_tick;
    mode_sel = 0;
    span_left = 0;
    hold_left = 0;
    rx_tick = 0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (span_left == 0) begin
        mode_sel = $urandom_range(0, 3);
        span_left = $urandom_range(20, 120);
      end
      span_left--;
      if (hold_request && hold_left == 0)
        hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0)
          hold_request = 1'b0;
        out_tready <= 1'b0;
      end else begin
        case (mode_sel)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (rx_tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_x(input logic signed [X_W-1:0] x);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0)
      burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-X_W){1'b0}}, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic program_poly();
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] value;
    idx = idx.first();
    repeat (idx.num()) begin
      if (idx == REG_DEGREE)
        value = ($urandom() & ~32'h7) | CFG_DATA_W'(next_degree);
      else
        value = next_coef[int'(idx) - int'(REG_COEF_0)];
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clk);
      idx = idx.next();
    end
    cfg_wr_en <= 1'b0;
    n_sets++;
  endtask

  function automatic logic signed [X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0: return X_MAX;
          1: return X_MIN;
          2: return '0;
          3: return -18'sd1;
          4: return 18'sd1;
          5: return X_ONE;
          6: return -X_ONE;
          default: return X_HALF;
        endcase
      end
      1, 2, 3: return X_W'(int'($urandom_range(0, 2 * 65536)) - 65536);
      default: return X_W'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return '1;
          default: return COEF_ONE;
        endcase
      end
      1, 2, 3, 4, 5: return COEF_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: degree zero, all coefficients zero
    send_x(X_MAX);
    send_x(X_MIN);
    drain_pipeline();

    // constant only, upper coefficients must not leak in
    next_degree = 3'd0;
    foreach (next_coef[i]) next_coef[i] = 32'h12345678;
    next_coef[0] = COEF_MAX;
    program_poly();
    send_x('0);
    send_x(X_MAX);
    send_x(X_MIN);
    drain_pipeline();

    // degree field above the limit clamps; drive the positive rail
    next_degree = 3'd7;
    foreach (next_coef[i]) next_coef[i] = COEF_MAX;
    program_poly();
    send_x(X_MAX);
    send_x(X_MIN);
    send_x('0);
    send_x(18'sd1);
    drain_pipeline();

    // full degree on the negative rail
    next_degree = 3'd6;
    foreach (next_coef[i]) next_coef[i] = COEF_MIN;
    program_poly();
    send_x(X_MAX);
    send_x(X_MIN);
    send_x(X_ONE);
    send_x(-X_ONE);
    send_x(-18'sd1);
    drain_pipeline();

    // rounding ties go toward plus infinity
    next_degree = 3'd1;
    foreach (next_coef[i]) next_coef[i] = '0;
    next_coef[1] = 32'sd1;
    program_poly();
    send_x(X_HALF);
    send_x(-X_HALF);
    send_x(18'sd98304);
    send_x(-18'sd98304);
    send_x(18'sd16384);
    drain_pipeline();

    // x^2 - 1 with the unused terms at the rail
    next_degree = 3'd2;
    foreach (next_coef[i]) next_coef[i] = COEF_MAX;
    next_coef[2] = COEF_ONE;
    next_coef[1] = '0;
    next_coef[0] = -COEF_ONE;
    program_poly();
    send_x(X_ONE);
    send_x('0);
    send_x(X_MAX);
    send_x(X_MIN);
    drain_pipeline();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      next_degree = 3'($urandom_range(0, 7));
      if (phase < 4)
        next_degree = 3'd6 - 3'(phase % 3);
      foreach (next_coef[i]) next_coef[i] = rand_coef();
      program_poly();
      gaps_on = (phase % 3 != 2);
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 10)
          hold_request = 1'b1;
        if ((phase == 5 && k == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
          drain_pipeline();
        send_x(rand_x());
      end
      drain_pipeline();
    end

    in_tvalid <= 1'b0;
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
    $display("Evaluated %0d samples under %0d coefficient sets, %0d results checked.",
             sb.n_items, n_sets, sb.n_checked);
    $display("Saturated results: %0d; mismatches: %0d.", sb.n_ovf, sb.n_errors);
    if (sb.n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
